>>> hdl/cpi_pkg.sv
// Shared types and constants for the color palette indexer.
// Used by cpi_ctrl, cpi_datapath and color_palette_indexer_top; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cpi_pkg;

  localparam int unsigned PALETTE_DEPTH = 256;

  localparam int unsigned PIXEL_W = 32;
  localparam int unsigned INDEX_W = 8;
  localparam int unsigned COUNT_W = 9;

  localparam int unsigned IDX_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(PALETTE_DEPTH + 1);

  localparam int unsigned GROUP_SIZE = 16;
  localparam int unsigned GRP_IDX_W  = $clog2(GROUP_SIZE);
  localparam int unsigned NUM_GROUPS = (PALETTE_DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int unsigned GRP_SEL_W  = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int unsigned PAD_DEPTH  = NUM_GROUPS * GROUP_SIZE;
  localparam int unsigned HIT_W      = GRP_SEL_W + GRP_IDX_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_FINISH
  } cpi_state_t;

  typedef struct packed {
    logic accept;
    logic reduce;
    logic finish;
  } cpi_cmd_t;

endpackage

`default_nettype wire

>>> hdl/cpi_ctrl.sv
// Controller state machine of the color palette indexer.
// Depends on cpi_pkg; drives the datapath commands and both handshakes.
`timescale 1ns / 1ps
`default_nettype none

module cpi_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output cpi_pkg::cpi_cmd_t     cmd
);
  import cpi_pkg::*;

  cpi_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        cmd.reduce = 1'b1;
        state_nxt  = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    out_valid_nxt = (out_valid_r && !out_ready) || cmd.finish;
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

>>> hdl/cpi_datapath.sv
// Datapath of the color palette indexer: palette entries, match row,
// grouped priority encoder, fill count and result registers. Depends on cpi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cpi_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire cpi_pkg::cpi_cmd_t             cmd,
  input  wire logic [cpi_pkg::PIXEL_W-1:0]   in_pixel_word,
  input  wire logic                          in_start_of_image,
  output logic      [cpi_pkg::INDEX_W-1:0]   out_color_index,
  output logic                               out_is_new_color,
  output logic                               out_overflow,
  output logic      [cpi_pkg::COUNT_W-1:0]   out_color_count
);
  import cpi_pkg::*;

  logic [PIXEL_W-1:0]   palette_r [PALETTE_DEPTH];
  logic [PIXEL_W-1:0]   pixel_r;
  logic [PAD_DEPTH-1:0] match_r, match_nxt;
  logic                 grp_any_r [NUM_GROUPS];
  logic                 grp_any_nxt [NUM_GROUPS];
  logic [GRP_IDX_W-1:0] grp_idx_r [NUM_GROUPS];
  logic [GRP_IDX_W-1:0] grp_idx_nxt [NUM_GROUPS];
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [CNT_W-1:0]     count_eff;

  logic [INDEX_W-1:0]   out_index_r, out_index_nxt;
  logic                 out_new_r, out_new_nxt;
  logic                 out_ovf_r;
  logic [COUNT_W-1:0]   out_count_r;

  logic                 hit;
  logic [GRP_SEL_W-1:0] hit_grp;
  logic [HIT_W-1:0]     hit_index;
  logic [HIT_W+INDEX_W-1:0] hit_ext;
  logic [CNT_W+INDEX_W-1:0] new_ext;
  logic [CNT_W+COUNT_W-1:0] cnt_ext;
  logic                 full;
  logic                 wr_en;

  assign count_eff = in_start_of_image ? '0 : count_r;

  always_comb begin
    match_nxt = '0;
    for (int i = 0; i < PALETTE_DEPTH; i++) begin
      match_nxt[i] = (palette_r[i] == in_pixel_word) && (CNT_W'(i) < count_eff);
    end
  end

  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      grp_any_nxt[g] = |match_r[g*GROUP_SIZE +: GROUP_SIZE];
      grp_idx_nxt[g] = '0;
      for (int k = GROUP_SIZE - 1; k >= 0; k--) begin
        if (match_r[g*GROUP_SIZE + k]) begin
          grp_idx_nxt[g] = GRP_IDX_W'(k);
        end
      end
    end
  end

  always_comb begin
    hit     = 1'b0;
    hit_grp = '0;
    for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
      if (grp_any_r[g]) begin
        hit     = 1'b1;
        hit_grp = GRP_SEL_W'(g);
      end
    end
    hit_index = {hit_grp, grp_idx_r[hit_grp]};
    hit_ext   = {{INDEX_W{1'b0}}, hit_index};
    new_ext   = {{INDEX_W{1'b0}}, count_r};
    full      = (count_r == CNT_W'(PALETTE_DEPTH));

    wr_en         = 1'b0;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    out_index_nxt = '0;
    out_new_nxt   = 1'b0;
    if (hit) begin
      out_index_nxt = hit_ext[INDEX_W-1:0];
    end else if (!full) begin
      wr_en         = cmd.finish;
      out_index_nxt = new_ext[INDEX_W-1:0];
      out_new_nxt   = 1'b1;
      count_nxt     = count_r + CNT_W'(1);
    end else begin
      ovf_nxt = 1'b1;
    end
    cnt_ext = {{COUNT_W{1'b0}}, count_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else if (cmd.accept) begin
      if (in_start_of_image) begin
        count_r <= '0;
        ovf_r   <= 1'b0;
      end
    end else if (cmd.finish) begin
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pixel_r <= in_pixel_word;
      match_r <= match_nxt;
    end
    if (cmd.reduce) begin
      grp_any_r <= grp_any_nxt;
      grp_idx_r <= grp_idx_nxt;
    end
    if (wr_en) begin
      palette_r[count_r[IDX_W-1:0]] <= pixel_r;
    end
    if (cmd.finish) begin
      out_index_r <= out_index_nxt;
      out_new_r   <= out_new_nxt;
      out_ovf_r   <= ovf_nxt;
      out_count_r <= cnt_ext[COUNT_W-1:0];
    end
  end

  assign out_color_index  = out_index_r;
  assign out_is_new_color = out_new_r;
  assign out_overflow     = out_ovf_r;
  assign out_color_count  = out_count_r;

endmodule

`default_nettype wire

>>> hdl/color_palette_indexer_top.sv
// Color palette indexer: maps each RGBA pixel to an index in a palette built
// in order of first appearance. Instantiates cpi_ctrl and cpi_datapath; uses cpi_pkg.
//
// The input channel takes one pixel per transaction together with a
// start-of-image flag, which empties the palette and clears the overflow flag
// before that pixel is looked up. The output channel returns one transaction
// per pixel: the palette index, a flag for a newly added color, the sticky
// overflow flag and the number of filled entries after this pixel.
// Each pixel is compared against all palette entries in the cycle it is
// accepted; a grouped priority encoder then finds the lowest match in the
// reduce step, and the finish step appends the color or reports overflow.
// The result register is loaded at the end of the finish step, so out_valid
// is high from then on. A new pixel is taken only once the previous one has finished.
// A finished result waits in the output register; the next pixel is accepted
// and searched meanwhile, and it stalls in its last step only while the
// receiver still holds the previous result. Reset empties the palette and
// clears the overflow flag; palette contents need no clearing.
`timescale 1ns / 1ps
`default_nettype none

module color_palette_indexer_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [cpi_pkg::PIXEL_W-1:0]   in_pixel_word,
  input  wire logic                          in_start_of_image,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [cpi_pkg::INDEX_W-1:0]   out_color_index,
  output logic                               out_is_new_color,
  output logic                               out_overflow,
  output logic      [cpi_pkg::COUNT_W-1:0]   out_color_count
);
  import cpi_pkg::*;

  cpi_cmd_t cmd;

  cpi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  cpi_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_pixel_word     (in_pixel_word),
    .in_start_of_image (in_start_of_image),
    .out_color_index   (out_color_index),
    .out_is_new_color  (out_is_new_color),
    .out_overflow      (out_overflow),
    .out_color_count   (out_color_count)
  );

endmodule

`default_nettype wire
